// ===== rtl/lcdsf_pkg.sv =====
// Package for the LCD serial framer: frame type, header codes and the font table.
`timescale 1ns / 1ps

package lcdsf_pkg;

	localparam int FRAME_BITS = 25;
	localparam int LEN_BITS   = 5;

	localparam logic [1:0] OP_COMMAND = 2'd0;
	localparam logic [1:0] OP_WRITE   = 2'd1;
	localparam logic [1:0] OP_CHAR    = 2'd2;

	localparam logic [2:0] HDR_COMMAND = 3'b100;
	localparam logic [2:0] HDR_WRITE   = 3'b101;
	localparam logic [5:0] BASE_ADDR   = 6'h24;
	localparam logic [2:0] MAX_NIBBLES = 3'd4;
	localparam logic [7:0] FONT_FIRST  = 8'h20;

	typedef struct packed {
		logic [FRAME_BITS-1:0] bits;
		logic [LEN_BITS-1:0]   len;
	} frame_t;

	localparam logic [15:0] GLYPHS [96] = '{
		16'h0000, 16'h0220, 16'h0060, 16'hC621, 16'hDA3D, 16'hD3AD, 16'hBC2A, 16'h0020,
		16'h0082, 16'h2100, 16'hA3A3, 16'h8221, 16'h0100, 16'h8001, 16'h020D, 16'h0180,
		16'h5DDC, 16'h00C4, 16'h9C59, 16'h185D, 16'hC045, 16'hD81A, 16'hDC1D, 16'h1190,
		16'hDC5D, 16'hD85D, 16'h4400, 16'h0120, 16'h8082, 16'h8809, 16'h2101, 16'h1251,
		16'h5CD9, 16'hD455, 16'h1A7D, 16'h5C18, 16'h1A7C, 16'hDC18, 16'hD410, 16'h5C1D,
		16'hC445, 16'h1A38, 16'h0C4C, 16'hC482, 16'h4C08, 16'h64C4, 16'h6446, 16'h5C5C,
		16'hD451, 16'h5C5E, 16'hD453, 16'hD81D, 16'h1230, 16'h4C4C, 16'h4580, 16'h4546,
		16'h2182, 16'hC241, 16'h1998, 16'h0238, 16'h2002, 16'h1A20, 16'h0102, 16'h0808,
		16'h2000, 16'hAE08, 16'hCE00, 16'h8C00, 16'h8E20, 16'h8D00, 16'h8231, 16'hDA20,
		16'hC600, 16'h0200, 16'h0E20, 16'h02A2, 16'h0228, 16'h8605, 16'h0205, 16'h8E00,
		16'hE400, 16'h00C5, 16'h8400, 16'hDA00, 16'hCC00, 16'h0E00, 16'h0500, 16'h0506,
		16'h2182, 16'h2280, 16'h8900, 16'hB900, 16'h4400, 16'h009B, 16'h8181, 16'h0000
	};

endpackage

// ===== rtl/lcdsf_frame_build.sv =====
// Frame builder: turns one request into a left-aligned bit frame and its length.
`timescale 1ns / 1ps

module lcdsf_frame_build #(
	parameter int NUM_POSITIONS = 10
) (
	input  logic [1:0]  operation,
	input  logic [7:0]  command_code,
	input  logic [5:0]  address,
	input  logic [15:0] write_data,
	input  logic [2:0]  nibble_count,
	input  logic [3:0]  position,
	input  logic [7:0]  character,
	output lcdsf_pkg::frame_t frame
);

	logic [2:0]  nib;
	logic [15:0] data_aligned;
	logic [15:0] data_rev;
	logic [15:0] glyph;
	logic [15:0] glyph_rev;
	logic [7:0]  ch;
	logic [6:0]  glyph_idx;
	logic [5:0]  char_addr;

	assign nib = (nibble_count > lcdsf_pkg::MAX_NIBBLES) ? lcdsf_pkg::MAX_NIBBLES
		: nibble_count;
	assign data_aligned = write_data << {(lcdsf_pkg::MAX_NIBBLES - nib), 2'b00};

	assign ch = (character < lcdsf_pkg::FONT_FIRST || character[7])
		? lcdsf_pkg::FONT_FIRST : character;
	assign glyph_idx = ch[6:0] - lcdsf_pkg::FONT_FIRST[6:0];
	assign glyph = lcdsf_pkg::GLYPHS[glyph_idx];
	assign char_addr = lcdsf_pkg::BASE_ADDR - {position, 2'b00};

	// each nibble goes out LSB first
	always_comb begin
		for (int n = 0; n < 4; n++) begin
			for (int b = 0; b < 4; b++) begin
				data_rev[n*4 + b]  = data_aligned[n*4 + 3 - b];
				glyph_rev[n*4 + b] = glyph[n*4 + 3 - b];
			end
		end
	end

	always_comb begin
		frame.bits = '0;
		frame.len  = '0;
		unique case (operation)
			lcdsf_pkg::OP_COMMAND: begin
				frame.bits = {lcdsf_pkg::HDR_COMMAND, command_code, 1'b1, 13'b0};
				frame.len  = 5'd12;
			end
			lcdsf_pkg::OP_WRITE: begin
				frame.bits = {lcdsf_pkg::HDR_WRITE, address, data_rev};
				frame.len  = 5'd9 + {nib, 2'b00};
			end
			lcdsf_pkg::OP_CHAR: begin
				frame.bits = {lcdsf_pkg::HDR_WRITE, char_addr, glyph_rev};
				frame.len  = ({28'd0, position} < NUM_POSITIONS) ? 5'd25 : 5'd0;
			end
			default: begin
				frame.bits = '0;
				frame.len  = '0;
			end
		endcase
	end

endmodule

// ===== rtl/lcdsf_shifter.sv =====
// Bit shifter: holds one frame and sends it one wire bit per accepted output.
`timescale 1ns / 1ps

module lcdsf_shifter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  lcdsf_pkg::frame_t frame,
	input  logic              bit_stall,
	output logic              busy,
	output logic              bit_valid,
	output logic              data_bit,
	output logic              last_bit
);

	logic [lcdsf_pkg::FRAME_BITS-1:0] frame_q;
	logic [lcdsf_pkg::LEN_BITS-1:0]   count_q;
	logic                             bit_take;

	assign bit_valid = (count_q != '0);
	assign data_bit  = frame_q[lcdsf_pkg::FRAME_BITS-1];
	assign last_bit  = (count_q == 5'd1);
	assign bit_take  = bit_valid && !bit_stall;
	// free once the final bit leaves in this cycle
	assign busy      = (count_q > 5'd1) || (last_bit && bit_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (load) begin
			count_q <= frame.len;
		end else if (bit_take) begin
			count_q <= count_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= frame.bits;
		end else if (bit_take) begin
			frame_q <= {frame_q[lcdsf_pkg::FRAME_BITS-2:0], 1'b0};
		end
	end

endmodule

// ===== rtl/lcd_controller_serial_framer.sv =====
// Top level of the LCD serial framer: request in, one serial wire bit per output.
// The first bit of a frame is offered in the cycle after the request is taken.
// Throughput: one bit per cycle while bit_stall is low; a frame is 0, 9 to 25 bits,
// and the single bit shifter holds off new requests until that frame has gone out;
// the next request is taken together with the last bit of the current frame.
// Reset clears the bit counter, so no bit is pending after reset.
`timescale 1ns / 1ps

module lcd_controller_serial_framer #(
	parameter int NUM_POSITIONS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  command_code,
	input  logic [5:0]  address,
	input  logic [15:0] write_data,
	input  logic [2:0]  nibble_count,
	input  logic [3:0]  position,
	input  logic [7:0]  character,
	output logic        bit_valid,
	input  logic        bit_stall,
	output logic        data_bit,
	output logic        last_bit
);

	lcdsf_pkg::frame_t frame;
	logic              busy;
	logic              load;

	assign item_stall = busy;
	assign load       = item_valid && !busy;

	lcdsf_frame_build #(
		.NUM_POSITIONS(NUM_POSITIONS)
	) u_build (
		.operation    (operation),
		.command_code (command_code),
		.address      (address),
		.write_data   (write_data),
		.nibble_count (nibble_count),
		.position     (position),
		.character    (character),
		.frame        (frame)
	);

	lcdsf_shifter u_shift (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.frame     (frame),
		.bit_stall (bit_stall),
		.busy      (busy),
		.bit_valid (bit_valid),
		.data_bit  (data_bit),
		.last_bit  (last_bit)
	);

endmodule

// ===== bench/lcdsf_frame_checker.sv =====
// Frame checker for the LCD serial framer: predicts the wire bits of each request and compares.
`timescale 1ns / 1ps

module lcdsf_frame_checker #(
	parameter int NUM_POSITIONS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  command_code,
	input  logic [5:0]  address,
	input  logic [15:0] write_data,
	input  logic [2:0]  nibble_count,
	input  logic [3:0]  position,
	input  logic [7:0]  character,
	input  logic        bit_valid,
	input  logic        bit_stall,
	input  logic        data_bit,
	input  logic        last_bit,
	output int          errors,
	output int          pending
);

	localparam logic [7:0] FONT_LAST = 8'h7F;

	typedef struct packed {
		logic data;
		logic last;
	} wire_bit_t;

	wire_bit_t bits_due[$];
	wire_bit_t want;
	int        fail_count = 0;
	int        due_count = 0;

	assign errors  = fail_count;
	assign pending = due_count;

	function automatic void predict_frame(input logic [1:0] op, input logic [7:0] cmd,
			input logic [5:0] addr, input logic [15:0] wdata, input logic [2:0] nib_in,
			input logic [3:0] pos, input logic [7:0] ch);
		logic      fb[$];
		logic [2:0] nib;
		logic [7:0] code;
		logic [5:0] waddr;
		logic [15:0] seg;
		logic [3:0] nibble;
		logic      is_write;
		wire_bit_t wb;
		is_write = 1'b0;
		waddr = addr;
		seg = wdata;
		nib = nib_in;
		case (op)
		lcdsf_pkg::OP_COMMAND: begin
			for (int k = 2; k >= 0; k--)
				fb.push_back(lcdsf_pkg::HDR_COMMAND[k]);
			for (int k = 7; k >= 0; k--)
				fb.push_back(cmd[k]);
			fb.push_back(1'b1);
		end
		lcdsf_pkg::OP_WRITE: begin
			is_write = 1'b1;
			if (nib_in > lcdsf_pkg::MAX_NIBBLES)
				nib = lcdsf_pkg::MAX_NIBBLES;
		end
		lcdsf_pkg::OP_CHAR: begin
			if (pos < NUM_POSITIONS) begin
				code = ch;
				// anything outside the font prints as a space
				if (code < lcdsf_pkg::FONT_FIRST || code > FONT_LAST)
					code = lcdsf_pkg::FONT_FIRST;
				seg = lcdsf_pkg::GLYPHS[code - lcdsf_pkg::FONT_FIRST];
				waddr = lcdsf_pkg::BASE_ADDR - {pos, 2'b00};
				nib = lcdsf_pkg::MAX_NIBBLES;
				is_write = 1'b1;
			end
		end
		default: ;
		endcase
		if (is_write) begin
			for (int k = 2; k >= 0; k--)
				fb.push_back(lcdsf_pkg::HDR_WRITE[k]);
			for (int k = 5; k >= 0; k--)
				fb.push_back(waddr[k]);
			// nibbles high first, each nibble LSB first
			for (int n = nib; n > 0; n--) begin
				nibble = seg[(n - 1) * 4 +: 4];
				for (int i = 0; i < 4; i++)
					fb.push_back(nibble[i]);
			end
		end
		foreach (fb[i]) begin
			wb.data = fb[i];
			wb.last = (i == fb.size() - 1);
			bits_due.push_back(wb);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (bit_valid && !bit_stall) begin
				if (bits_due.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected bit, expected none, got data %0b last %0b",
						$time, data_bit, last_bit);
				end else begin
					want = bits_due.pop_front();
					if (data_bit !== want.data) begin
						fail_count++;
						$display("%0t: data_bit expected %0b got %0b",
							$time, want.data, data_bit);
					end
					if (last_bit !== want.last) begin
						fail_count++;
						$display("%0t: last_bit expected %0b got %0b",
							$time, want.last, last_bit);
					end
				end
			end
			if (item_valid && !item_stall)
				predict_frame(operation, command_code, address, write_data, nibble_count,
					position, character);
		end
		due_count = bits_due.size();
	end

endmodule

// ===== bench/lcd_controller_serial_framer_test.sv =====
// Testbench top for the LCD serial framer: request stimulus, output stall pattern and verdict.
`timescale 1ns / 1ps

module lcd_controller_serial_framer_test;

	localparam int         NUM_POSITIONS = 10;
	localparam logic [1:0] OP_UNUSED     = 2'd3;
	localparam int         IDLE_LIMIT    = 2000;
	localparam int         HOLD_CYCLES   = 400;
	localparam int         RANDOM_FRAMES = 350;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic [1:0]  operation = '0;
	logic [7:0]  command_code = '0;
	logic [5:0]  address = '0;
	logic [15:0] write_data = '0;
	logic [2:0]  nibble_count = '0;
	logic [3:0]  position = '0;
	logic [7:0]  character = '0;
	logic        bit_stall = 1'b0;
	logic        item_stall;
	logic        bit_valid;
	logic        data_bit;
	logic        last_bit;
	int          errors;
	int          pending;

	int idle_cycles = 0;
	int burst_left = 0;
	int rx_mode = 0;
	int mode_left = 0;
	int hold_left = 0;
	bit hold_request = 1'b0;
	bit rx_toggle = 1'b0;
	int frames_sent = 0;
	int req_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	lcd_controller_serial_framer #(
		.NUM_POSITIONS(NUM_POSITIONS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.operation(operation),
		.command_code(command_code),
		.address(address),
		.write_data(write_data),
		.nibble_count(nibble_count),
		.position(position),
		.character(character),
		.bit_valid(bit_valid),
		.bit_stall(bit_stall),
		.data_bit(data_bit),
		.last_bit(last_bit)
	);

	lcdsf_frame_checker #(
		.NUM_POSITIONS(NUM_POSITIONS)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.operation(operation),
		.command_code(command_code),
		.address(address),
		.write_data(write_data),
		.nibble_count(nibble_count),
		.position(position),
		.character(character),
		.bit_valid(bit_valid),
		.bit_stall(bit_stall),
		.data_bit(data_bit),
		.last_bit(last_bit),
		.errors(errors),
		.pending(pending)
	);

	task automatic send_request(input logic [1:0] op, input logic [7:0] cmd,
			input logic [5:0] addr, input logic [15:0] wdata, input logic [2:0] nib,
			input logic [3:0] pos, input logic [7:0] ch);
		operation    <= op;
		command_code <= cmd;
		address      <= addr;
		write_data   <= wdata;
		nibble_count <= nib;
		position     <= pos;
		character    <= ch;
		item_valid   <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	// bursts of requests with random gaps between them
	task automatic pace_sender;
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_random;
		logic [1:0] op;
		logic [2:0] nib;
		logic [3:0] pos;
		logic [7:0] ch;
		int         pick;
		pick = $urandom_range(0, 19);
		if (pick < 6)
			op = lcdsf_pkg::OP_COMMAND;
		else if (pick < 12)
			op = lcdsf_pkg::OP_WRITE;
		else if (pick < 19)
			op = lcdsf_pkg::OP_CHAR;
		else
			op = OP_UNUSED;
		nib = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
		pos = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
			: 4'($urandom_range(0, NUM_POSITIONS - 1));
		ch = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(lcdsf_pkg::FONT_FIRST, 8'h7F));
		send_request(op, 8'($urandom), 6'($urandom), 16'($urandom), nib, pos, ch);
		if (op == lcdsf_pkg::OP_COMMAND || op == lcdsf_pkg::OP_WRITE
				|| (op == lcdsf_pkg::OP_CHAR && pos < NUM_POSITIONS))
			frames_sent++;
	endtask

	task automatic wait_drained;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// output side: random stall modes, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			bit_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			rx_toggle = !rx_toggle;
			case (rx_mode)
			0: bit_stall <= 1'b0;
			1: bit_stall <= ($urandom_range(0, 3) == 0);
			2: bit_stall <= ($urandom_range(0, 3) != 0);
			default: bit_stall <= rx_toggle;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (bit_valid && !bit_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(lcdsf_pkg::OP_COMMAND, 8'h00, 6'h00, 16'h0000, 3'd0, 4'd0, 8'h00);
		send_request(lcdsf_pkg::OP_COMMAND, 8'hFF, 6'h3F, 16'hFFFF, 3'd7, 4'd15, 8'hFF);
		send_request(lcdsf_pkg::OP_COMMAND, 8'hA5, 6'h15, 16'h5A5A, 3'd2, 4'd3, 8'h41);
		send_request(lcdsf_pkg::OP_WRITE, 8'h00, 6'h3F, 16'hFFFF, 3'd0, 4'd0, 8'h00);
		send_request(lcdsf_pkg::OP_WRITE, 8'hFF, 6'h00, 16'h0000, 3'd1, 4'd15, 8'hFF);
		send_request(lcdsf_pkg::OP_WRITE, 8'h12, 6'h2A, 16'h1234, 3'd2, 4'd0, 8'h20);
		send_request(lcdsf_pkg::OP_WRITE, 8'h34, 6'h15, 16'hABCD, 3'd3, 4'd9, 8'h7F);
		send_request(lcdsf_pkg::OP_WRITE, 8'h56, 6'h3F, 16'hFFFF, 3'd4, 4'd1, 8'h30);
		send_request(lcdsf_pkg::OP_WRITE, 8'h78, 6'h01, 16'hC3A5, 3'd5, 4'd2, 8'h00);
		send_request(lcdsf_pkg::OP_WRITE, 8'h9A, 6'h20, 16'h8001, 3'd7, 4'd4, 8'h80);
		pace_sender();
		send_request(lcdsf_pkg::OP_CHAR, 8'h00, 6'h00, 16'h0000, 3'd0, 4'd0, 8'h41);
		send_request(lcdsf_pkg::OP_CHAR, 8'hFF, 6'h3F, 16'hFFFF, 3'd7, 4'd9, 8'h7E);
		send_request(lcdsf_pkg::OP_CHAR, 8'h00, 6'h00, 16'h0000, 3'd4, 4'd10, 8'h41);
		send_request(lcdsf_pkg::OP_CHAR, 8'h00, 6'h00, 16'h0000, 3'd4, 4'd15, 8'h30);
		send_request(lcdsf_pkg::OP_CHAR, 8'h00, 6'h00, 16'h0000, 3'd4, 4'd5, 8'h1F);
		send_request(lcdsf_pkg::OP_CHAR, 8'h00, 6'h00, 16'h0000, 3'd4, 4'd6, 8'h80);
		send_request(lcdsf_pkg::OP_CHAR, 8'h00, 6'h00, 16'h0000, 3'd4, 4'd7, 8'hFF);
		send_request(lcdsf_pkg::OP_CHAR, 8'h00, 6'h00, 16'h0000, 3'd4, 4'd8, 8'h7F);
		send_request(lcdsf_pkg::OP_CHAR, 8'h00, 6'h00, 16'h0000, 3'd4, 4'd1, 8'h20);
		send_request(lcdsf_pkg::OP_CHAR, 8'h00, 6'h00, 16'h0000, 3'd4, 4'd2, 8'h00);
		send_request(OP_UNUSED, 8'hFF, 6'h3F, 16'hFFFF, 3'd4, 4'd0, 8'h41);
		send_request(lcdsf_pkg::OP_COMMAND, 8'h5A, 6'h00, 16'h0000, 3'd0, 4'd0, 8'h00);
		item_valid <= 1'b0;
		wait_drained();

		while (frames_sent < RANDOM_FRAMES) begin
			req_count++;
			if (req_count == 120)
				hold_request = 1'b1;
			if (req_count == 250) begin
				item_valid <= 1'b0;
				wait_drained();
			end
			send_random();
			pace_sender();
		end
		item_valid <= 1'b0;

		wait_drained();
		repeat (30) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/lcdsf_pkg.sv
rtl/lcdsf_frame_build.sv
rtl/lcdsf_shifter.sv
rtl/lcd_controller_serial_framer.sv
bench/lcdsf_frame_checker.sv
bench/lcd_controller_serial_framer_test.sv
